### hw/rtl/closest_point_on_segment_3d_unit_defines.svh
// assertion macros for the closest point on segment unit
// used by cps3_div and closest_point_on_segment_3d_unit, expects clock and reset in scope
`ifndef CLOSEST_POINT_ON_SEGMENT_3D_UNIT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_3D_UNIT_DEFINES_SVH

// concurrent check sampled on the clock, off during reset
`define CPS3_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that holds even while reset is asserted
`define CPS3_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/cps3_pkg.sv
// widths, codes, types and helper functions of the closest point on segment unit
// no dependencies
package cps3_pkg;

   localparam int CW  = 32;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 2;
   localparam int NCH = 3;
   localparam int KW  = (SW + NCH - 1) / NCH;
   localparam int QW  = DW + 1;
   localparam int PRW = DW + SW + 1;

   localparam logic [1:0] WHERE_INTERIOR = 2'd0;
   localparam logic [1:0] WHERE_START    = 2'd1;
   localparam logic [1:0] WHERE_END      = 2'd2;
   localparam logic [1:0] WHERE_DEGEN    = 2'd3;

   typedef struct packed {
      logic [2:0][CW-1:0] base;
      logic [2:0]         dneg;
      logic [1:0]         code;
   } side_type;

   typedef struct packed {
      logic [SW-1:0] rem;
      logic [QW-1:0] lo;
   } div_lane_type;

   // one restoring division step, quotient bit shifts into lo
   function automatic div_lane_type div_step(div_lane_type s, logic [SW-1:0] den);
      logic [SW:0]  t;
      logic [SW:0]  diff;
      div_lane_type r;
      t    = {s.rem, s.lo[QW-1]};
      diff = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
         r.rem = diff[SW-1:0];
         r.lo  = {s.lo[QW-2:0], 1'b1};
      end else begin
         r.rem = t[SW-1:0];
         r.lo  = {s.lo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   // start plus signed offset, clamped to the coordinate range
   function automatic logic [CW-1:0] offset_sat(logic [CW-1:0] a, logic [QW-1:0] q,
                                                logic neg);
      logic signed [CW+2:0] sa;
      logic signed [CW+2:0] sq;
      logic signed [CW+2:0] sum;
      logic [CW-1:0]        res;
      sa  = (CW+3)'($signed(a));
      sq  = $signed({1'b0, q});
      sum = neg ? (sa - sq) : (sa + sq);
      if (sum > (CW+3)'($signed({1'b0, {(CW-1){1'b1}}})))
         res = {1'b0, {(CW-1){1'b1}}};
      else if (sum < (CW+3)'($signed({1'b1, {(CW-1){1'b0}}})))
         res = {1'b1, {(CW-1){1'b0}}};
      else
         res = sum[CW-1:0];
      return res;
   endfunction

endpackage

### hw/rtl/closest_point_on_segment_3d_unit.sv
// Closest point on a 3D segment, signed Q16.16. One transfer enters per cycle while rsp is not
// stalled; the result passes through six arithmetic stages (differences, products, sums, case
// decision, partial products, final sum), a 34-stage one-bit-per-stage divider, and the output register.
// A stall on rsp holds the whole pipeline and drops req_tready in the same cycle.
// depends on cps3_pkg, cps3_div and the unit defines header
`include "closest_point_on_segment_3d_unit_defines.svh"

module closest_point_on_segment_3d_unit
   import cps3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
   // query_x, query_y, query_z
   input  logic [9*CW-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // near_x, near_y, near_z
   output logic [3*CW-1:0]  rsp_tdata,
   // where_code
   output logic [1:0]       rsp_tuser
);

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic                    vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff;
   logic [2:0][CW-1:0]      a1_ff, b1_ff, a2_ff, b2_ff, a3_ff, b3_ff;
   logic signed [DW-1:0]    d1_ff [3];
   logic signed [DW-1:0]    v1_ff [3];
   logic [2:0][DW-1:0]      md2_ff, md3_ff, md4_ff;
   logic [PW-1:0]           sq2_ff [3];
   logic [PW-1:0]           pr2_ff [3];
   logic [2:0]              sn2_ff, dneg2_ff, dneg3_ff;
   logic [SW-1:0]           den3_ff, pos3_ff, neg3_ff;
   logic [SW-1:0]           den4_ff, num4_ff, half4_ff, den5_ff, half5_ff, den6_ff;
   side_type                side4_ff, side5_ff, side6_ff;
   logic [DW+KW-1:0]        p5_ff [3][NCH];
   logic [PRW-1:0]          pr6_ff [3];
   logic [1:0]              code4_in;
   logic [SW:0]             rhs;
   logic [NCH*KW-1:0]       numx;
   div_lane_type [2:0]      lane6;
   logic                    dv_vld;
   side_type                dv_side;
   logic [2:0][QW-1:0]      dv_q;
   logic                    out_vld_ff;
   logic [2:0][CW-1:0]      near_ff;
   logic [1:0]              code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0; vld2_ff <= 1'b0; vld3_ff <= 1'b0;
         vld4_ff <= 1'b0; vld5_ff <= 1'b0; vld6_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_tvalid; vld2_ff <= vld1_ff; vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff; vld5_ff <= vld4_ff; vld6_ff <= vld5_ff;
         out_vld_ff <= dv_vld;
      end
   end

   always_comb begin
      rhs = {1'b0, den3_ff} + {1'b0, neg3_ff};
      if (den3_ff == '0)
         code4_in = WHERE_DEGEN;
      else if (pos3_ff <= neg3_ff)
         code4_in = WHERE_START;
      else if ({1'b0, pos3_ff} >= rhs)
         code4_in = WHERE_END;
      else
         code4_in = WHERE_INTERIOR;
      numx = (NCH*KW)'(num4_ff);
      for (int l = 0; l < 3; l++) begin
         lane6[l].rem = pr6_ff[l][PRW-1:QW];
         lane6[l].lo  = pr6_ff[l][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // differences
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= req_tdata[i*CW +: CW];
            b1_ff[i] <= req_tdata[(3+i)*CW +: CW];
            d1_ff[i] <= DW'($signed(req_tdata[(3+i)*CW +: CW]))
                      - DW'($signed(req_tdata[i*CW +: CW]));
            v1_ff[i] <= DW'($signed(req_tdata[(6+i)*CW +: CW]))
                      - DW'($signed(req_tdata[i*CW +: CW]));
         end
         // products of magnitudes
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         for (int i = 0; i < 3; i++) begin
            md2_ff[i]   <= d1_ff[i][DW-1] ? DW'(-d1_ff[i]) : DW'(d1_ff[i]);
            sq2_ff[i]   <= PW'(d1_ff[i][DW-1] ? DW'(-d1_ff[i]) : DW'(d1_ff[i]))
                         * PW'(d1_ff[i][DW-1] ? DW'(-d1_ff[i]) : DW'(d1_ff[i]));
            pr2_ff[i]   <= PW'(d1_ff[i][DW-1] ? DW'(-d1_ff[i]) : DW'(d1_ff[i]))
                         * PW'(v1_ff[i][DW-1] ? DW'(-v1_ff[i]) : DW'(v1_ff[i]));
            sn2_ff[i]   <= d1_ff[i][DW-1] ^ v1_ff[i][DW-1];
            dneg2_ff[i] <= d1_ff[i][DW-1];
         end
         // dot products split by sign
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
         md3_ff   <= md2_ff;
         dneg3_ff <= dneg2_ff;
         den3_ff  <= SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);
         pos3_ff  <= (sn2_ff[0] ? '0 : SW'(pr2_ff[0])) + (sn2_ff[1] ? '0 : SW'(pr2_ff[1]))
                   + (sn2_ff[2] ? '0 : SW'(pr2_ff[2]));
         neg3_ff  <= (sn2_ff[0] ? SW'(pr2_ff[0]) : '0) + (sn2_ff[1] ? SW'(pr2_ff[1]) : '0)
                   + (sn2_ff[2] ? SW'(pr2_ff[2]) : '0);
         // case decision
         md4_ff        <= md3_ff;
         den4_ff       <= den3_ff;
         num4_ff       <= pos3_ff - neg3_ff;
         half4_ff      <= den3_ff >> 1;
         side4_ff.code <= code4_in;
         side4_ff.dneg <= dneg3_ff;
         side4_ff.base <= (code4_in == WHERE_END) ? b3_ff : a3_ff;
         // partial products of offset numerator
         den5_ff  <= den4_ff;
         half5_ff <= half4_ff;
         side5_ff <= side4_ff;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < NCH; k++) begin
               p5_ff[i][k] <= (DW+KW)'(md4_ff[i]) * (DW+KW)'(numx[k*KW +: KW]);
            end
         end
         // numerator plus half divisor for rounding
         den6_ff  <= den5_ff;
         side6_ff <= side5_ff;
         for (int i = 0; i < 3; i++) begin
            pr6_ff[i] <= PRW'(p5_ff[i][0]) + (PRW'(p5_ff[i][1]) << KW)
                       + (PRW'(p5_ff[i][2]) << (2*KW)) + PRW'(half5_ff);
         end
         // output register
         code_ff <= dv_side.code;
         for (int i = 0; i < 3; i++) begin
            near_ff[i] <= (dv_side.code == WHERE_INTERIOR)
                        ? offset_sat(dv_side.base[i], dv_q[i], dv_side.dneg[i])
                        : dv_side.base[i];
         end
      end
   end

   cps3_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (vld6_ff),
      .in_den   (den6_ff),
      .in_side  (side6_ff),
      .in_lane  (lane6),
      .out_vld  (dv_vld),
      .out_side (dv_side),
      .out_q    (dv_q)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = near_ff;
   assign rsp_tuser  = code_ff;

   `CPS3_ASSERT(a_stall_blocks_req, (rsp_tvalid && !rsp_tready) |-> !req_tready, "req taken during stall")
   `CPS3_ASSERT(a_interior_ratio, (vld4_ff && side4_ff.code == WHERE_INTERIOR) |-> (num4_ff != '0 && num4_ff < den4_ff), "interior ratio out of range")
   `CPS3_ASSERT(a_degen_zero_den, (vld4_ff && side4_ff.code == WHERE_DEGEN) |-> (den4_ff == '0), "degenerate code with nonzero length")

endmodule

### hw/rtl/cps3_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor
// depends on cps3_pkg and the unit defines header
`include "closest_point_on_segment_3d_unit_defines.svh"

module cps3_div
   import cps3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  logic [SW-1:0]         in_den,
   input  side_type              in_side,
   input  div_lane_type [2:0]    in_lane,
   output logic                  out_vld,
   output side_type              out_side,
   output logic [2:0][QW-1:0]    out_q
);

   logic [QW:1]        vld_ff;
   logic [SW-1:0]      den_ff  [1:QW];
   side_type           side_ff [1:QW];
   div_lane_type [2:0] lane_ff [1:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-1:1], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[1]  <= in_den;
         side_ff[1] <= in_side;
         for (int l = 0; l < 3; l++) begin
            lane_ff[1][l] <= div_step(in_lane[l], in_den);
         end
         for (int s = 2; s <= QW; s++) begin
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
            for (int l = 0; l < 3; l++) begin
               lane_ff[s][l] <= div_step(lane_ff[s-1][l], den_ff[s-1]);
            end
         end
      end
   end

   assign out_vld  = vld_ff[QW];
   assign out_side = side_ff[QW];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_q[l] = lane_ff[QW][l].lo;
      end
   end

   `CPS3_ASSERT(a_rem_below_den, (out_vld && out_side.code == WHERE_INTERIOR) |-> (lane_ff[QW][0].rem < den_ff[QW] && lane_ff[QW][1].rem < den_ff[QW] && lane_ff[QW][2].rem < den_ff[QW]), "remainder not below divisor")
   `CPS3_ASSERT(a_hold_on_stall, !adv |=> $stable(lane_ff[QW]), "divider output moved during stall")
   `CPS3_ASSERT(a_valid_moves, adv |=> (vld_ff[QW] == $past(vld_ff[QW-1])), "valid bit lost in divider")

endmodule
